[hdl/tar_header_stream_checker_core_macros.svh]
// ---------------------------------------------------------------------------
// tar header stream checker macros
// assertion helpers shared by the checker rtl, empty for synthesis
// ---------------------------------------------------------------------------
`ifndef TAR_HEADER_STREAM_CHECKER_CORE_MACROS_SVH
`define TAR_HEADER_STREAM_CHECKER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define TARHSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tarhsc assertion failed");
// next-cycle implication, disabled during reset
`define TARHSC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tarhsc assertion failed");
`else
`define TARHSC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TARHSC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hdl/tarhsc_pkg.sv]
// ---------------------------------------------------------------------------
// tarhsc_pkg
// types and constants of the tar header stream checker
// ---------------------------------------------------------------------------
package tarhsc_pkg;

    localparam int unsigned RECORD_BYTES = 512;
    localparam int unsigned POS_W        = 9;
    localparam int unsigned SUM_W        = 17;
    localparam int unsigned CHK_W        = 24;
    localparam int unsigned SIZE_W       = 36;
    localparam int unsigned RECS_W       = 28;

    localparam logic [POS_W-1:0] RECORD_LAST = POS_W'(RECORD_BYTES - 1);
    localparam logic [POS_W-1:0] SIZE_FIRST  = 9'd124;
    localparam logic [POS_W-1:0] SIZE_LAST   = 9'd135;
    localparam logic [POS_W-1:0] CHK_FIRST   = 9'd148;
    localparam logic [POS_W-1:0] CHK_LAST    = 9'd155;
    localparam logic [POS_W-1:0] TYPE_POS    = 9'd156;

    localparam logic [SUM_W-1:0] SPACES_SUM  = 17'd256;
    localparam logic [7:0]       CHAR_SPACE  = 8'h20;
    localparam logic [7:0]       CHAR_ZERO   = 8'h30;
    localparam logic [7:0]       CHAR_SEVEN  = 8'h37;

    typedef enum logic [2:0] {
        PH_LEAD   = 3'b001,
        PH_DIGITS = 3'b010,
        PH_DONE   = 3'b100
    } phase_t;

    typedef enum logic [2:0] {
        MODE_HEADER = 3'b001,
        MODE_SKIP   = 3'b010,
        MODE_ENDED  = 3'b100
    } mode_t;

    typedef struct packed {
        logic       vld;
        logic [7:0] data;
    } in_item_t;

    typedef struct packed {
        logic              header_ok;
        logic              regular_file;
        logic [7:0]        entry_type;
        logic [SIZE_W-1:0] entry_size;
        logic [RECS_W-1:0] data_records;
        logic [SUM_W-1:0]  computed_sum;
        logic              archive_end;
    } result_t;

    typedef struct packed {
        logic ended;
        logic skipping;
        logic skip_zero;
    } status_t;

    typedef struct packed {
        phase_t            phase;
        logic [SIZE_W-1:0] acc;
    } oct_t;

    // one octal digit step, spaces skipped only before the first digit
    function automatic oct_t octal_step(phase_t ph, logic [7:0] b, logic [SIZE_W-1:0] acc);
        oct_t r;
        r.phase = ph;
        r.acc   = acc;
        if (!(ph == PH_LEAD && b == CHAR_SPACE)) begin
            if ((ph == PH_LEAD || ph == PH_DIGITS) && (b inside {[CHAR_ZERO:CHAR_SEVEN]})) begin
                r.phase = PH_DIGITS;
                r.acc   = {acc[SIZE_W-4:0], b[2:0]};
            end
            else begin
                r.phase = PH_DONE;
            end
        end
        return r;
    endfunction

endpackage

[hdl/tarhsc_in_stage.sv]
// ---------------------------------------------------------------------------
// tarhsc_in_stage
// input register for one archive byte
// ---------------------------------------------------------------------------
module tarhsc_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [7:0]          archive_byte,
    input  logic                consume,
    output logic                in_stall,
    output tarhsc_pkg::in_item_t item
);

    logic       vld_reg;
    logic       vld_next;
    logic [7:0] data_reg;

    // held byte that cannot move on blocks the port
    assign in_stall = vld_reg && !consume;
    assign vld_next = in_stall ? vld_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            data_reg <= archive_byte;
        end
    end

    assign item.vld  = vld_reg;
    assign item.data = data_reg;

endmodule

[hdl/tarhsc_parse.sv]
// ---------------------------------------------------------------------------
// tarhsc_parse
// record walk, header sum and octal field parsing
// ---------------------------------------------------------------------------
module tarhsc_parse (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tarhsc_pkg::in_item_t item,
    input  logic                 out_ready,
    output logic                 consume,
    output logic                 res_fire,
    output tarhsc_pkg::result_t  res,
    output tarhsc_pkg::status_t  status
);

    logic [tarhsc_pkg::POS_W-1:0]  pos_reg,   pos_next;
    logic [tarhsc_pkg::SUM_W-1:0]  sum_reg,   sum_next;
    logic [tarhsc_pkg::CHK_W-1:0]  chk_reg,   chk_next;
    logic [tarhsc_pkg::SIZE_W-1:0] size_reg,  size_next;
    logic [7:0]                    type_reg,  type_next;
    logic [tarhsc_pkg::RECS_W-1:0] skip_reg,  skip_next;
    tarhsc_pkg::phase_t            phase_reg, phase_next;
    tarhsc_pkg::mode_t             mode_reg,  mode_next;

    logic                            produce;
    logic [tarhsc_pkg::SUM_W-1:0]    sum_add;
    logic [tarhsc_pkg::SIZE_W:0]     size_round;
    logic [tarhsc_pkg::RECS_W-1:0]   skip_dec;
    logic                            ok;
    logic                            at_end;
    tarhsc_pkg::phase_t              ph_eff;
    tarhsc_pkg::oct_t                oct;

    assign sum_add    = tarhsc_pkg::SUM_W'(sum_reg + {9'd0, item.data});
    assign size_round = {1'b0, size_reg} + (tarhsc_pkg::SIZE_W+1)'(tarhsc_pkg::RECORD_BYTES - 1);
    assign skip_dec   = skip_reg - tarhsc_pkg::RECS_W'(1);
    assign ok         = {7'd0, sum_add} == chk_reg;
    assign at_end     = sum_add == tarhsc_pkg::SPACES_SUM;
    assign produce    = (mode_reg == tarhsc_pkg::MODE_HEADER) && (pos_reg == tarhsc_pkg::RECORD_LAST);
    assign consume    = item.vld && (!produce || out_ready);
    assign res_fire   = consume && produce;

    // each field restarts its parse at its first byte
    assign ph_eff = (pos_reg == tarhsc_pkg::SIZE_FIRST || pos_reg == tarhsc_pkg::CHK_FIRST)
                  ? tarhsc_pkg::PH_LEAD : phase_reg;
    assign oct    = tarhsc_pkg::octal_step(ph_eff, item.data,
                        (pos_reg <= tarhsc_pkg::SIZE_LAST) ? size_reg
                                                           : {12'd0, chk_reg});

    assign res.header_ok    = ok;
    assign res.regular_file = (type_reg == 8'd0) || (type_reg == tarhsc_pkg::CHAR_ZERO);
    assign res.entry_type   = type_reg;
    assign res.entry_size   = size_reg;
    assign res.data_records = size_round[tarhsc_pkg::SIZE_W:9];
    assign res.computed_sum = sum_add;
    assign res.archive_end  = at_end;

    always_comb
    begin
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        chk_next   = chk_reg;
        size_next  = size_reg;
        type_next  = type_reg;
        skip_next  = skip_reg;
        phase_next = phase_reg;
        mode_next  = mode_reg;
        if (consume)
        begin
            pos_next = pos_reg + tarhsc_pkg::POS_W'(1);
            case (mode_reg)
                tarhsc_pkg::MODE_SKIP:
                begin
                    if (pos_reg == tarhsc_pkg::RECORD_LAST)
                    begin
                        skip_next = skip_dec;
                        if (skip_dec == '0)
                        begin
                            mode_next = tarhsc_pkg::MODE_HEADER;
                        end
                    end
                end
                tarhsc_pkg::MODE_HEADER:
                begin
                    phase_next = ph_eff;
                    if (pos_reg inside {[tarhsc_pkg::SIZE_FIRST:tarhsc_pkg::SIZE_LAST]})
                    begin
                        size_next  = oct.acc;
                        phase_next = oct.phase;
                    end
                    if (pos_reg inside {[tarhsc_pkg::CHK_FIRST:tarhsc_pkg::CHK_LAST]})
                    begin
                        chk_next   = oct.acc[tarhsc_pkg::CHK_W-1:0];
                        phase_next = oct.phase;
                    end
                    else
                    begin
                        sum_next = sum_add;
                    end
                    if (pos_reg == tarhsc_pkg::TYPE_POS)
                    begin
                        type_next = item.data;
                    end
                    if (produce)
                    begin
                        if (at_end)
                        begin
                            mode_next = tarhsc_pkg::MODE_ENDED;
                        end
                        else if (ok && res.data_records != '0)
                        begin
                            skip_next = res.data_records;
                            mode_next = tarhsc_pkg::MODE_SKIP;
                        end
                        sum_next   = tarhsc_pkg::SPACES_SUM;
                        chk_next   = '0;
                        size_next  = '0;
                        type_next  = '0;
                        phase_next = tarhsc_pkg::PH_LEAD;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            sum_reg   <= tarhsc_pkg::SPACES_SUM;
            chk_reg   <= '0;
            size_reg  <= '0;
            type_reg  <= '0;
            skip_reg  <= '0;
            phase_reg <= tarhsc_pkg::PH_LEAD;
            mode_reg  <= tarhsc_pkg::MODE_HEADER;
        end
        else
        begin
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
            chk_reg   <= chk_next;
            size_reg  <= size_next;
            type_reg  <= type_next;
            skip_reg  <= skip_next;
            phase_reg <= phase_next;
            mode_reg  <= mode_next;
        end
    end

    assign status.ended     = mode_reg == tarhsc_pkg::MODE_ENDED;
    assign status.skipping  = mode_reg == tarhsc_pkg::MODE_SKIP;
    assign status.skip_zero = skip_reg == '0;

endmodule

[hdl/tarhsc_out_stage.sv]
// ---------------------------------------------------------------------------
// tarhsc_out_stage
// result register towards the receiver
// ---------------------------------------------------------------------------
module tarhsc_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                res_fire,
    input  tarhsc_pkg::result_t res,
    input  logic                out_stall,
    output logic                out_ready,
    output logic                out_valid,
    output tarhsc_pkg::result_t out_res
);

    logic                vld_reg;
    logic                vld_next;
    tarhsc_pkg::result_t res_reg;

    assign out_ready = !vld_reg || !out_stall;
    assign vld_next  = res_fire || (vld_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_fire)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = vld_reg;
    assign out_res   = res_reg;

endmodule

[hdl/tar_header_stream_checker_core.sv]
// ---------------------------------------------------------------------------
// tar_header_stream_checker_core
// walks a tar archive byte by byte and checks each header record
// ---------------------------------------------------------------------------
// usage
//   input channel: one archive byte per request on archive_byte, taken at a
//   clock edge with in_valid high and in_stall low
//   output channel: one request per header record, carrying the checksum
//   verdict, type byte, parsed size, data record count, computed sum and
//   the end-of-archive flag, taken with out_valid high and out_stall low
//   throughput: one byte per cycle while in_stall is low, set by the single
//   parse stage between the input register and the result register
//   result: the header request is loaded into the result register as the
//   last byte of the header passes on from the input register
//   data records after a matching header are passed over with no request;
//   after an all-zero record every byte is absorbed until reset
//   reset: record position cleared, walk back in header mode, both
//   registers empty; no clearing pass is needed
//   stall: a waiting result does not block bytes that give no result; only
//   the last byte of the next header waits, and then in_stall rises
// ---------------------------------------------------------------------------
`include "tar_header_stream_checker_core_macros.svh"

module tar_header_stream_checker_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  archive_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        header_ok,
    output logic        regular_file,
    output logic [7:0]  entry_type,
    output logic [35:0] entry_size,
    output logic [27:0] data_records,
    output logic [16:0] computed_sum,
    output logic        archive_end
);

    tarhsc_pkg::in_item_t item;
    tarhsc_pkg::result_t  res;
    tarhsc_pkg::result_t  out_res;
    tarhsc_pkg::status_t  status;
    logic                 consume;
    logic                 res_fire;
    logic                 out_ready;

    // input register
    tarhsc_in_stage u_in (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .archive_byte (archive_byte),
        .consume      (consume),
        .in_stall     (in_stall),
        .item         (item)
    );

    // record walk and header parse
    tarhsc_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .out_ready (out_ready),
        .consume   (consume),
        .res_fire  (res_fire),
        .res       (res),
        .status    (status)
    );

    // result register
    tarhsc_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_fire  (res_fire),
        .res       (res),
        .out_stall (out_stall),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    assign header_ok    = out_res.header_ok;
    assign regular_file = out_res.regular_file;
    assign entry_type   = out_res.entry_type;
    assign entry_size   = out_res.entry_size;
    assign data_records = out_res.data_records;
    assign computed_sum = out_res.computed_sum;
    assign archive_end  = out_res.archive_end;

    // no header request once the archive has ended
    `TARHSC_ASSERT_IMP(a_no_result_after_end, clk, rst_n, status.ended, !res_fire)
    // skipping always has records left to pass over
    `TARHSC_ASSERT_IMP(a_skip_count_live, clk, rst_n, status.skipping, !status.skip_zero)
    // a non-empty entry always rounds up to at least one record
    `TARHSC_ASSERT_IMP(a_records_nonzero, clk, rst_n,
        out_valid && (entry_size != 36'd0), data_records != 28'd0)
    // a new header request only replaces a result that has gone
    `TARHSC_ASSERT_IMP(a_no_overwrite, clk, rst_n, res_fire, !out_valid || !out_stall)

endmodule
